// ===== rtl/ghcb_pkg.sv =====
`default_nettype none
package ghcb_pkg;

    // Width of the length-type configuration registers.
    localparam int CFG_LEN_W = 18;
    localparam int HASH_W = 64;
    localparam int BYTE_W = 8;
    localparam int GEAR_ENTRIES = 256;
    localparam int GEAR_IDX_W = 8;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [CFG_LEN_W-1:0] MIN_CHUNK_RST = 18'd2048;
    localparam logic [CFG_LEN_W-1:0] MAX_CHUNK_RST = 18'd65536;
    localparam logic [CFG_LEN_W-1:0] NORMAL_SPAN_RST = 18'd8192;
    localparam logic [HASH_W-1:0] STRICT_MASK_RST = 64'h0000_d90f_0353_0000;
    localparam logic [HASH_W-1:0] LOOSE_MASK_RST = 64'h0000_d900_0353_0000;

    typedef enum logic [2:0] {
        REG_MIN_CHUNK   = 3'd0,
        REG_MAX_CHUNK   = 3'd1,
        REG_NORMAL_SPAN = 3'd2,
        REG_STRICT_MASK = 3'd3,
        REG_LOOSE_MASK  = 3'd4
    } reg_index_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_DATA = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic stream_end;
        logic last_of_run;
    } res_flags_t;

    typedef struct packed {
        logic [CFG_LEN_W-1:0] min_chunk;
        logic [CFG_LEN_W-1:0] max_chunk;
        logic [CFG_LEN_W-1:0] normal_span;
        logic [HASH_W-1:0]    strict_mask;
        logic [HASH_W-1:0]    loose_mask;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/ghcb_res_fifo.sv =====
`default_nettype none
module ghcb_res_fifo #(
    parameter int WIDTH = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_count,
    input  wire logic [WIDTH-1:0] push_data0,
    input  wire logic [WIDTH-1:0] push_data1,
    output logic                  room_two,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign room_two  = (count_reg <= (PTR_W+1)'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push_count) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_data1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ghcb_cut_core.sv =====
`default_nettype none
module ghcb_cut_core #(
    parameter int LENGTH_BITS = 18
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic                         is_data,
    input  wire logic                         end_flag,
    input  wire logic [ghcb_pkg::HASH_W-1:0]  gear,
    input  wire ghcb_pkg::cfg_t               cfg,
    output logic [1:0]                        res_count,
    output logic [LENGTH_BITS-1:0]            res_len0,
    output ghcb_pkg::res_flags_t              res_flags0,
    output logic [LENGTH_BITS-1:0]            res_len1,
    output ghcb_pkg::res_flags_t              res_flags1
);

    // Common width for all length compares, wide enough for sums of two lengths.
    localparam int CW = ((LENGTH_BITS > ghcb_pkg::CFG_LEN_W) ?
                         LENGTH_BITS : ghcb_pkg::CFG_LEN_W) + 2;

    logic [ghcb_pkg::HASH_W-1:0] fp_reg;
    logic [ghcb_pkg::HASH_W-1:0] fp_next;
    logic [LENGTH_BITS-1:0]      pos_reg;
    logic [LENGTH_BITS-1:0]      pos_next;

    logic [ghcb_pkg::HASH_W-1:0] fp_hash;
    logic [ghcb_pkg::HASH_W-1:0] mask;
    logic [CW-1:0]               pos_w;
    logic [CW-1:0]               min_w;
    logic [CW-1:0]               norm_w;
    logic [CW-1:0]               len_w;
    logic                        hashing;
    logic                        cut;
    logic                        close;

    always_comb
    begin
        pos_w   = CW'(pos_reg);
        min_w   = (cfg.min_chunk == '0) ? CW'(1) : CW'(cfg.min_chunk);
        norm_w  = min_w + CW'(cfg.normal_span);
        hashing = (pos_w >= min_w);
        mask    = (pos_w < norm_w) ? cfg.strict_mask : cfg.loose_mask;
        fp_hash = {fp_reg[ghcb_pkg::HASH_W-2:0], 1'b0} + gear;
        cut     = hashing && ((fp_hash & mask) == '0);
        len_w   = cut ? CW'(1) : (pos_w + CW'(1));
        close   = (len_w >= CW'(cfg.max_chunk))
               || (len_w >= CW'({LENGTH_BITS{1'b1}}))
               || end_flag;

        if (cut || close)
        begin
            fp_next = '0;
        end
        else if (hashing)
        begin
            fp_next = fp_hash;
        end
        else
        begin
            fp_next = fp_reg;
        end
        pos_next = close ? '0 : len_w[LENGTH_BITS-1:0];

        // A cut result, if any, always goes first; the closing result follows.
        res_count = is_data ? (2'(cut) + 2'(close)) : 2'd0;
        if (cut)
        begin
            res_len0               = pos_reg;
            res_flags0.stream_end  = 1'b0;
            res_flags0.last_of_run = !close;
        end
        else
        begin
            res_len0               = len_w[LENGTH_BITS-1:0];
            res_flags0.stream_end  = end_flag;
            res_flags0.last_of_run = 1'b1;
        end
        res_len1               = len_w[LENGTH_BITS-1:0];
        res_flags1.stream_end  = end_flag;
        res_flags1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg  <= '0;
            pos_reg <= '0;
        end
        else if (fire && is_data)
        begin
            fp_reg  <= fp_next;
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gear_hash_chunk_boundary.sv =====
// A word is registered with its gear table entry in the stage register; its results then
// go to a four-entry result queue drained by the single output port. Throughput: one word
// per cycle while the queue has room for two results; a byte closing two chunks gives two
// results. Gear table loads are stored at their accept edge and read by later data bytes.
// Reset clears the fingerprint, chunk position, pipeline and queue and loads register
// defaults; the gear table is not cleared and must be loaded before data is sent.
`default_nettype none
module gear_hash_chunk_boundary #(
    parameter int LENGTH_BITS = 18
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ghcb_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ghcb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ghcb_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [ghcb_pkg::GEAR_IDX_W-1:0]   gear_index,
    input  wire logic [ghcb_pkg::HASH_W-1:0]       gear_value,
    input  wire logic [ghcb_pkg::BYTE_W-1:0]       data_byte,
    input  wire logic                              end_of_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [LENGTH_BITS-1:0]                 chunk_length,
    output logic                                   stream_end,
    output logic                                   last_of_run
);

    localparam int RES_W = LENGTH_BITS + 2;

    ghcb_pkg::cfg_t cfg_reg;
    ghcb_pkg::reg_index_t reg_sel;
    logic cfg_wr;

    logic [ghcb_pkg::HASH_W-1:0] gear_mem [ghcb_pkg::GEAR_ENTRIES];
    logic [ghcb_pkg::HASH_W-1:0] gear_rd_reg;
    logic s1_valid_reg;
    logic s1_data_reg;
    logic s1_end_reg;

    logic in_acc;
    logic room_two;
    logic s1_fire;

    logic [1:0]                res_count;
    logic [LENGTH_BITS-1:0]    res_len0;
    logic [LENGTH_BITS-1:0]    res_len1;
    ghcb_pkg::res_flags_t      res_flags0;
    ghcb_pkg::res_flags_t      res_flags1;
    logic [RES_W-1:0]          pop_data;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_sel = ghcb_pkg::reg_index_t'(paddr[ghcb_pkg::APB_ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_chunk   <= ghcb_pkg::MIN_CHUNK_RST;
            cfg_reg.max_chunk   <= ghcb_pkg::MAX_CHUNK_RST;
            cfg_reg.normal_span <= ghcb_pkg::NORMAL_SPAN_RST;
            cfg_reg.strict_mask <= ghcb_pkg::STRICT_MASK_RST;
            cfg_reg.loose_mask  <= ghcb_pkg::LOOSE_MASK_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                ghcb_pkg::REG_MIN_CHUNK:
                    cfg_reg.min_chunk <= pwdata[ghcb_pkg::CFG_LEN_W-1:0];
                ghcb_pkg::REG_MAX_CHUNK:
                    cfg_reg.max_chunk <= pwdata[ghcb_pkg::CFG_LEN_W-1:0];
                ghcb_pkg::REG_NORMAL_SPAN:
                    cfg_reg.normal_span <= pwdata[ghcb_pkg::CFG_LEN_W-1:0];
                ghcb_pkg::REG_STRICT_MASK:
                    cfg_reg.strict_mask <= pwdata;
                ghcb_pkg::REG_LOOSE_MASK:
                    cfg_reg.loose_mask <= pwdata;
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            ghcb_pkg::REG_MIN_CHUNK:
                prdata = ghcb_pkg::APB_DATA_W'(cfg_reg.min_chunk);
            ghcb_pkg::REG_MAX_CHUNK:
                prdata = ghcb_pkg::APB_DATA_W'(cfg_reg.max_chunk);
            ghcb_pkg::REG_NORMAL_SPAN:
                prdata = ghcb_pkg::APB_DATA_W'(cfg_reg.normal_span);
            ghcb_pkg::REG_STRICT_MASK:
                prdata = cfg_reg.strict_mask;
            ghcb_pkg::REG_LOOSE_MASK:
                prdata = cfg_reg.loose_mask;
            default:
                prdata = '0;
        endcase
    end

    // The stage register advances only when the queue can take two results.
    assign s1_fire  = s1_valid_reg && room_two;
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_acc   = in_valid && in_ready;

    // Loads are written at their own accept edge, so a data byte accepted
    // afterwards always reads the new entry.
    always_ff @(posedge clk)
    begin
        if (in_acc && (req_type == ghcb_pkg::REQ_LOAD))
        begin
            gear_mem[gear_index] <= gear_value;
        end
        if (in_acc)
        begin
            gear_rd_reg <= gear_mem[data_byte];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_data_reg <= (req_type == ghcb_pkg::REQ_DATA);
            s1_end_reg  <= end_of_data;
        end
    end

    ghcb_cut_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_cut_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .is_data    (s1_data_reg),
        .end_flag   (s1_end_reg),
        .gear       (gear_rd_reg),
        .cfg        (cfg_reg),
        .res_count  (res_count),
        .res_len0   (res_len0),
        .res_flags0 (res_flags0),
        .res_len1   (res_len1),
        .res_flags1 (res_flags1)
    );

    ghcb_res_fifo #(
        .WIDTH (RES_W)
    ) u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (s1_fire ? res_count : 2'd0),
        .push_data0 ({res_len0, res_flags0}),
        .push_data1 ({res_len1, res_flags1}),
        .room_two   (room_two),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (pop_data)
    );

    assign chunk_length = pop_data[RES_W-1:2];
    assign stream_end   = pop_data[1];
    assign last_of_run  = pop_data[0];

endmodule
`default_nettype wire
